>>> sv/i2cm_pkg.sv
`timescale 1ns / 1ps
// Types, codes and quarter-period program tables for the I2C master byte engine.
// Self-contained; imported by i2c_master_byte_engine.
package i2cm_pkg;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] address;
    logic        read_not_write;
    logic [7:0]  write_data;
    logic [1:0]  ack_mode;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] scl_drive;
    logic [1:0] sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
    logic       bus_active;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_IDLE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_NAKSTOP = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHIFT = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] sda;
    logic [1:0] scl;
  } quarter_t;

  localparam logic [1:0] PIN_LOW  = 2'd0;
  localparam logic [1:0] PIN_HIGH = 2'd1;
  localparam logic [1:0] PIN_REL  = 2'd2;

  localparam logic [1:0] ST_ACK      = 2'd0;
  localparam logic [1:0] ST_NAK      = 2'd1;
  localparam logic [1:0] ST_ADDR_ERR = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  localparam logic [15:0] ADDR_MAX    = 16'h007F;
  localparam logic [15:0] QPT_RESET   = 16'd60;

  localparam logic [5:0] LEN_START    = 6'd39;
  localparam logic [5:0] LEN_STOP     = 6'd3;
  localparam logic [5:0] LEN_WRITE    = 6'd36;
  localparam logic [5:0] LEN_READ_ACK = 6'd29;
  localparam logic [5:0] LEN_READ_NO  = 6'd25;

  // x mod 3 using 4 = 1 (mod 3): add base-4 digits, fold once more
  function automatic logic [1:0] mod3_5b(input logic [4:0] x);
    logic [2:0] s;
    logic [2:0] t;
    s = {1'b0, x[1:0]} + {1'b0, x[3:2]} + {2'b00, x[4]};
    t = {2'b00, s[2]} + {1'b0, s[1:0]};
    return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
  endfunction

  // one of the 36 quarters of an address or data byte plus its ack slot
  function automatic quarter_t byte_quarter(input logic [5:0] q, input logic msb);
    quarter_t r;
    r.kind = KIND_NONE;
    if (q < 6'd32) begin
      r.sda = {1'b0, msb};
      r.scl = (q[1:0] == 2'd1 || q[1:0] == 2'd2) ? PIN_HIGH : PIN_LOW;
      if (q[1:0] == 2'd3) r.kind = KIND_SHIFT;
    end else begin
      r.sda = PIN_REL;
      r.scl = (q == 6'd33 || q == 6'd34) ? PIN_HIGH : PIN_LOW;
      if (q == 6'd33) r.kind = KIND_ACK;
    end
    return r;
  endfunction

  function automatic quarter_t quarter_f(input cmd_t cmd, input logic [5:0] p,
                                         input logic msb, input logic [1:0] ack_choice);
    quarter_t   r;
    logic [1:0] sub;
    r.kind = KIND_NONE;
    r.sda  = PIN_REL;
    r.scl  = PIN_REL;
    sub    = mod3_5b(5'(p - 6'd1));
    case (cmd)
      CMD_START: begin
        if (p == 6'd0) begin
          r.sda = PIN_HIGH;
          r.scl = PIN_HIGH;
        end else if (p == 6'd1) begin
          r.sda = PIN_LOW;
          r.scl = PIN_HIGH;
        end else if (p == 6'd2) begin
          r.sda = PIN_LOW;
          r.scl = PIN_LOW;
        end else begin
          r = byte_quarter(p - 6'd3, msb);
        end
      end
      CMD_WRITE: r = byte_quarter(p, msb);
      CMD_STOP, CMD_NAKSTOP: begin
        // last quarter leaves both lines released for the stop edge
        if (p == 6'd0) begin
          r.sda = PIN_LOW;
          r.scl = PIN_LOW;
        end else if (p == 6'd1) begin
          r.sda = PIN_LOW;
          r.scl = PIN_HIGH;
        end
      end
      CMD_READ: begin
        if (p == 6'd0) begin
          r.scl = PIN_LOW;
        end else if (p <= 6'd24) begin
          r.scl = (sub < 2'd2) ? PIN_HIGH : PIN_LOW;
          if (sub == 2'd0) r.kind = KIND_READ;
        end else begin
          r.sda = {1'b0, ack_choice[0]};
          r.scl = (p == 6'd26 || p == 6'd27) ? PIN_HIGH : PIN_LOW;
        end
      end
      default: r.kind = KIND_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] seq_len(input cmd_t cmd, input logic [1:0] ack_choice);
    case (cmd)
      CMD_START:             return LEN_START;
      CMD_STOP, CMD_NAKSTOP: return LEN_STOP;
      CMD_WRITE:             return LEN_WRITE;
      CMD_READ:              return (ack_choice <= 2'd1) ? LEN_READ_ACK : LEN_READ_NO;
      default:               return 6'd0;
    endcase
  endfunction

endpackage

>>> sv/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// I2C master byte engine: command sequencer with registered result and skid stage.
// Depends on i2cm_pkg for beat types, command codes and quarter tables.
//
// Usage: every input beat on in_data is one tick of the bus sequencer. It
// carries an optional command (start, stop, write byte, read byte) and the
// sampled SDA level. A command is taken only while the engine is idle; the
// engine then walks its quarter-period program, each quarter lasting
// quarter_period_ticks ticks (written through cfg_write_en/cfg_write_data
// while idle, reset value 60, zero acts as one).
// Each accepted beat yields exactly one result beat on out_data: pin drives
// for that tick, busy, a one-tick done pulse with status, the last read byte
// and the bus state.
// Each result beat is registered; throughput is one beat per cycle while the
// receiver does not stall, set by the single pass of next-state logic ahead
// of the result register.
// Reset (rst, synchronous) returns to idle with both pins released, the
// bus marked free and the result channel empty.
// When the receiver stalls, the result register holds and one further beat
// lands in a skid register; in_stall rises only while that skid is full.
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [15:0] quarter_period_ticks;
  cmd_t        active_command, active_command_next;
  logic [5:0]  phase_step, phase_step_next;
  logic [15:0] quarter_counter, quarter_counter_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [1:0]  ack_choice, ack_choice_next;
  logic        bus_started, bus_started_next;
  logic        ack_seen, ack_seen_next;
  logic [1:0]  scl_pin_state, scl_pin_state_next;
  logic [1:0]  sda_pin_state, sda_pin_state_next;
  logic [7:0]  rx_byte, rx_byte_next;

  logic        done_flag, busy_flag;
  logic [1:0]  status_code;
  logic [1:0]  scl_tick, sda_tick;
  out_item_t   step_result;

  logic        skid_valid;
  out_item_t   skid_data;
  logic        in_fire, out_free;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state for one tick
  always_comb begin
    quarter_t    q;
    logic [15:0] qc_inc;
    q                    = '0;
    qc_inc               = '0;
    active_command_next  = active_command;
    phase_step_next      = phase_step;
    quarter_counter_next = quarter_counter;
    shift_byte_next      = shift_byte;
    ack_choice_next      = ack_choice;
    bus_started_next     = bus_started;
    ack_seen_next        = ack_seen;
    scl_pin_state_next   = scl_pin_state;
    sda_pin_state_next   = sda_pin_state;
    rx_byte_next         = rx_byte;
    done_flag            = 1'b0;
    busy_flag            = 1'b0;
    status_code          = ST_ACK;

    if (active_command == CMD_IDLE) begin
      case (in_data.req_type)
        CMD_START: begin
          if (in_data.address > ADDR_MAX) begin
            done_flag   = 1'b1;
            status_code = ST_ADDR_ERR;
          end else begin
            shift_byte_next     = {in_data.address[6:0], in_data.read_not_write};
            ack_seen_next       = 1'b0;
            active_command_next = CMD_START;
          end
        end
        CMD_STOP: begin
          if (bus_started) begin
            active_command_next = CMD_STOP;
          end else begin
            done_flag   = 1'b1;
            status_code = ST_NONE;
          end
        end
        CMD_WRITE: begin
          shift_byte_next     = in_data.write_data;
          ack_seen_next       = 1'b0;
          active_command_next = CMD_WRITE;
        end
        CMD_READ: begin
          ack_choice_next     = in_data.ack_mode;
          shift_byte_next     = 8'd0;
          active_command_next = CMD_READ;
        end
        default: ;
      endcase
      if (active_command_next != CMD_IDLE) begin
        phase_step_next      = 6'd0;
        quarter_counter_next = 16'd0;
        q = quarter_f(active_command_next, 6'd0, shift_byte_next[7], ack_choice_next);
        scl_pin_state_next = q.scl;
        sda_pin_state_next = q.sda;
      end
    end

    // pins seen on the bus during this tick
    scl_tick = scl_pin_state_next;
    sda_tick = sda_pin_state_next;

    if (active_command_next != CMD_IDLE) begin
      busy_flag = 1'b1;
      qc_inc    = quarter_counter_next + 16'd1;
      if (qc_inc >= quarter_period_ticks) begin
        q = quarter_f(active_command_next, phase_step_next, shift_byte_next[7],
                      ack_choice_next);
        quarter_counter_next = 16'd0;
        case (q.kind)
          KIND_SHIFT: shift_byte_next = {shift_byte_next[6:0], 1'b0};
          KIND_ACK:   ack_seen_next   = in_data.sda_in;
          KIND_READ:  shift_byte_next = {shift_byte_next[6:0], in_data.sda_in};
          default:    ;
        endcase
        phase_step_next = phase_step_next + 6'd1;
        if (phase_step_next >= seq_len(active_command_next, ack_choice_next)) begin
          phase_step_next = 6'd0;
          done_flag       = 1'b1;
          case (active_command_next)
            CMD_START: begin
              bus_started_next = 1'b1;
              status_code      = ST_ACK;
              if (ack_seen_next) begin
                // address not acknowledged: release the bus before reporting
                done_flag = 1'b0;
                q = quarter_f(CMD_NAKSTOP, 6'd0, shift_byte_next[7], ack_choice_next);
                scl_pin_state_next = q.scl;
                sda_pin_state_next = q.sda;
              end
            end
            CMD_NAKSTOP: begin
              bus_started_next = 1'b0;
              status_code      = ST_NAK;
            end
            CMD_STOP: begin
              bus_started_next = 1'b0;
              status_code      = ST_NONE;
            end
            CMD_WRITE: status_code = {1'b0, ack_seen_next};
            default: begin
              rx_byte_next = shift_byte_next;
              status_code  = ST_NONE;
            end
          endcase
          active_command_next = done_flag ? CMD_IDLE : CMD_NAKSTOP;
          if (done_flag) busy_flag = 1'b0;
        end else begin
          q = quarter_f(active_command_next, phase_step_next, shift_byte_next[7],
                        ack_choice_next);
          scl_pin_state_next = q.scl;
          sda_pin_state_next = q.sda;
        end
      end else begin
        quarter_counter_next = qc_inc;
      end
    end
  end

  // result beat for this tick
  always_comb begin
    step_result.scl_drive  = scl_tick;
    step_result.sda_drive  = sda_tick;
    step_result.busy_res   = busy_flag;
    step_result.done_res   = done_flag;
    step_result.status     = done_flag ? status_code : ST_ACK;
    step_result.read_data  = rx_byte_next;
    step_result.bus_active = bus_started_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_period_ticks <= QPT_RESET;
    end else if (cfg_write_en) begin
      quarter_period_ticks <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_command  <= CMD_IDLE;
      phase_step      <= 6'd0;
      quarter_counter <= 16'd0;
      shift_byte      <= 8'd0;
      ack_choice      <= 2'd0;
      bus_started     <= 1'b0;
      ack_seen        <= 1'b0;
      scl_pin_state   <= PIN_REL;
      sda_pin_state   <= PIN_REL;
      rx_byte         <= 8'd0;
    end else if (in_fire) begin
      active_command  <= active_command_next;
      phase_step      <= phase_step_next;
      quarter_counter <= quarter_counter_next;
      shift_byte      <= shift_byte_next;
      ack_choice      <= ack_choice_next;
      bus_started     <= bus_started_next;
      ack_seen        <= ack_seen_next;
      scl_pin_state   <= scl_pin_state_next;
      sda_pin_state   <= sda_pin_state_next;
      rx_byte         <= rx_byte_next;
    end
  end

  // result register with one-beat skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : step_result;
    end
    if (!out_free && in_fire) begin
      skid_data <= step_result;
    end
  end

  a_busy_done_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.busy_res && out_data.done_res))
    else $error("busy and done reported on the same beat");

  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.done_res) |-> (out_data.status == ST_ACK))
    else $error("status set on a beat without done");

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    (active_command == CMD_IDLE) |-> (phase_step == 6'd0 && quarter_counter == 16'd0))
    else $error("phase or quarter counter left running while idle");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while the result register is empty");

endmodule
